FILE: rtl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 64;

    typedef enum logic [2:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_REVERSE    = 3'd4,
        FN_STATUS     = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    // controller -> datapath
    typedef struct packed {
        logic exec;   // request accepted this edge: update pointers, write slot
        logic fetch;  // read front and back slots into the read registers
    } t_ctl_cmd;

endpackage

FILE: rtl/deq_ctrl.sv
module deq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output logic               o_valid,
    output deq_pkg::t_ctl_cmd  o_cmd
);
    import deq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_valid <= 1'b0;
                    if (start) begin
                        r_state <= S_READ;
                        r_busy  <= 1'b1;
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_cmd.exec  = start && (r_state == S_IDLE);
    assign o_cmd.fetch = (r_state == S_READ);
    assign busy        = r_busy;
    assign o_valid     = r_valid;

endmodule

FILE: rtl/deq_dpath.sv
module deq_dpath #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  deq_pkg::t_ctl_cmd     i_cmd,
    input  logic [2:0]            i_func,
    input  logic [DATA_WIDTH-1:0] i_data_in,
    output logic [DATA_WIDTH-1:0] o_front_word,
    output logic [DATA_WIDTH-1:0] o_back_word,
    output logic [CW-1:0]         o_entry_count,
    output logic                  o_is_empty,
    output logic [1:0]            o_op_error
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = CW + 1;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic                  r_rev;
    t_err                  r_err;
    logic [DATA_WIDTH-1:0] r_rd_lo;
    logic [DATA_WIDTH-1:0] r_rd_hi;

    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;
    logic          n_rev;
    t_err          n_err;

    logic          full;
    logic          empty;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [SW-1:0] hi_sum;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] hi_addr;
    logic [AW-1:0] tail_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          put_low;
    logic          put_high;
    logic          drop_low;
    logic          drop_high;
    logic [DATA_WIDTH-1:0] lo_word;
    logic [DATA_WIDTH-1:0] hi_word;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    // slot just past the last element
    assign hi_sum  = SW'(r_head) + SW'(r_count);
    assign hi_addr = (hi_sum >= SW'(DEPTH)) ? AW'(hi_sum - SW'(DEPTH)) : AW'(hi_sum);

    // last occupied slot, meaningful only when not empty
    assign tail_sum  = hi_sum - SW'(1);
    assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                                : AW'(tail_sum);

    always_comb begin
        put_low   = 1'b0;
        put_high  = 1'b0;
        drop_low  = 1'b0;
        drop_high = 1'b0;
        n_rev     = r_rev;
        n_err     = ERR_NONE;
        unique case (t_func'(i_func))
            FN_PUSH_BACK: begin
                if (full) n_err = ERR_FULL;
                else if (r_rev) put_low = 1'b1;
                else put_high = 1'b1;
            end
            FN_PUSH_FRONT: begin
                if (full) n_err = ERR_FULL;
                else if (r_rev) put_high = 1'b1;
                else put_low = 1'b1;
            end
            FN_POP_FRONT: begin
                if (empty) n_err = ERR_EMPTY;
                else if (r_rev) drop_high = 1'b1;
                else drop_low = 1'b1;
            end
            FN_POP_BACK: begin
                if (empty) n_err = ERR_EMPTY;
                else if (r_rev) drop_low = 1'b1;
                else drop_high = 1'b1;
            end
            FN_REVERSE: n_rev = ~r_rev;
            default: ;
        endcase

        n_head = r_head;
        if (put_low) n_head = head_dec;
        else if (drop_low) n_head = head_inc;

        n_count = r_count;
        if (put_low || put_high) n_count = r_count + CW'(1);
        else if (drop_low || drop_high) n_count = r_count - CW'(1);

        wr_en   = i_cmd.exec && (put_low || put_high);
        wr_addr = put_low ? head_dec : hi_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
            r_err   <= ERR_NONE;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_data_in;
        end
        if (i_cmd.fetch) begin
            r_rd_lo <= mem[r_head];
            r_rd_hi <= mem[tail_addr];
        end
    end

    assign lo_word = empty ? '0 : r_rd_lo;
    assign hi_word = empty ? '0 : r_rd_hi;

    assign o_front_word  = r_rev ? hi_word : lo_word;
    assign o_back_word   = r_rev ? lo_word : hi_word;
    assign o_entry_count = r_count;
    assign o_is_empty    = empty;
    assign o_op_error    = r_err;

endmodule

FILE: rtl/double_ended_queue.sv
// A request accepted in S_IDLE updates the pointers and writes its slot; S_READ then loads
//   the front and back slots into the read registers, and the result appears with o_valid.
// A new request is taken only in S_IDLE, not while busy; busy is high during S_READ, which
//   reads the front and back slots out of the ring memory.
// Reset (synchronous, i_rst_n low): queue empty, head at slot zero, direction normal.
// The receiver cannot stall; each result is shown for exactly one cycle.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            i_func,
    input  logic [DATA_WIDTH-1:0] i_data_in,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_front_word,
    output logic [DATA_WIDTH-1:0] o_back_word,
    output logic [CW-1:0]         o_entry_count,
    output logic                  o_is_empty,
    output logic [1:0]            o_op_error
);
    import deq_pkg::*;

    t_ctl_cmd cmd;

    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    deq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_func),
        .i_data_in     (i_data_in),
        .o_front_word  (o_front_word),
        .o_back_word   (o_back_word),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_op_error    (o_op_error)
    );

endmodule

FILE: rtl/deq_checker.sv
module deq_checker #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [DATA_WIDTH-1:0] o_front_word,
    input logic [DATA_WIDTH-1:0] o_back_word,
    input logic [CW-1:0]         o_entry_count,
    input logic                  o_is_empty
);
    import deq_pkg::*;

    // every accepted request (start while not busy) is followed by a result strobe on o_valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_valid)
        else $error("no result two cycles after accepted request");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= CW'(DEPTH)))
        else $error("count above depth");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> (o_front_word == '0) && (o_back_word == '0))
        else $error("nonzero words from empty queue");

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_front_word  (o_front_word),
    .o_back_word   (o_back_word),
    .o_entry_count (o_entry_count),
    .o_is_empty    (o_is_empty)
);
